/* rtl/lsi_pkg.sv */
// ============================================================================
// Lattice smootherstep interpolator package
// Shared codes, field widths and fixed-point constants of the interpolator.
// ============================================================================
package lsi_pkg;

  // Item kinds carried in the slave-side tuser bit.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Field widths of the stream items and the spacing register.
  localparam int unsigned POS_W       = 6;
  localparam int unsigned SPACING_W   = 6;
  localparam int unsigned HIN_W       = 12;
  localparam int unsigned HOUT_W      = 12;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  // Reset value of the corner spacing.
  localparam logic [SPACING_W-1:0] SPACING_RST = 6'd5;

  // Unsigned Q0.16 fractions and Q1.16 fade weights.
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned WGT_W  = FRAC_W + 1;
  localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

  // Coefficients of the quintic fade 6t^5 - 15t^4 + 10t^3.
  localparam int unsigned FADE_K5 = 6;
  localparam int unsigned FADE_K4 = 15;
  localparam int unsigned FADE_K3 = 10;

endpackage

/* rtl/lsi_frac.sv */
// ============================================================================
// Fraction divider
// Two-stage restoring divider that turns an in-cell offset into the Q0.16
// fraction floor(offset * 2^16 / spacing), eight quotient bits per stage.
// ============================================================================
module lsi_frac
  import lsi_pkg::*;
(
  input  logic              clk_i,
  input  logic [1:0]        en_i,    // load enables of the two stages
  input  logic [POS_W-1:0]  rem_i,   // offset in the cell, below the spacing
  input  logic [POS_W-1:0]  div_i,   // spacing, never zero
  output logic [FRAC_W-1:0] frac_o
);

  localparam int unsigned HALF_W = FRAC_W / 2;

  // One restoring step: the top bit is the quotient bit, the rest the remainder.
  function automatic logic [POS_W:0] div_step(input logic [POS_W-1:0] rem,
                                              input logic [POS_W-1:0] dv);
    logic [POS_W:0] dbl;
    logic [POS_W:0] res;
    dbl = {rem, 1'b0};
    if (dbl >= {1'b0, dv}) begin
      res = {1'b1, POS_W'(dbl - {1'b0, dv})};
    end else begin
      res = {1'b0, dbl[POS_W-1:0]};
    end
    return res;
  endfunction

  logic [POS_W-1:0]  rem_a_d, rem_a_q;
  logic [HALF_W-1:0] quo_a_d, quo_a_q;
  logic [HALF_W-1:0] quo_b;
  logic [FRAC_W-1:0] frac_d, frac_q;

  // Upper eight quotient bits.
  always_comb begin
    logic [POS_W:0]   st;
    logic [POS_W-1:0] r;
    r       = rem_i;
    quo_a_d = '0;
    for (int i = 0; i < HALF_W; i++) begin
      st                   = div_step(r, div_i);
      quo_a_d[HALF_W-1-i]  = st[POS_W];
      r                    = st[POS_W-1:0];
    end
    rem_a_d = r;
  end

  // Lower eight quotient bits.
  always_comb begin
    logic [POS_W:0]   st;
    logic [POS_W-1:0] r;
    r     = rem_a_q;
    quo_b = '0;
    for (int i = 0; i < HALF_W; i++) begin
      st                 = div_step(r, div_i);
      quo_b[HALF_W-1-i]  = st[POS_W];
      r                  = st[POS_W-1:0];
    end
    frac_d = {quo_a_q, quo_b};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_a_q <= rem_a_d;
      quo_a_q <= quo_a_d;
    end
    if (en_i[1]) begin
      frac_q <= frac_d;
    end
  end

  assign frac_o = frac_q;

endmodule

/* rtl/lsi_fade.sv */
// ============================================================================
// Quintic fade
// Three-stage pipeline for f = t^3 * (6t^2 - 15t + 10) in unsigned Q0.16,
// one multiplier per stage, saturated to the largest Q0.16 value.
// ============================================================================
module lsi_fade
  import lsi_pkg::*;
(
  input  logic              clk_i,
  input  logic [2:0]        en_i,    // load enables of the three stages
  input  logic [FRAC_W-1:0] t_i,
  output logic [FRAC_W-1:0] fade_o
);

  localparam int unsigned SQ_W  = 2 * FRAC_W;       // t*t
  localparam int unsigned POL_W = SQ_W + 4;         // exact Q32 polynomial
  localparam int unsigned P_W   = POL_W - FRAC_W;   // polynomial in Q16
  localparam int unsigned F_W   = FRAC_W + P_W;     // t^3 * p

  logic [SQ_W-1:0]   sq_d, sq_q;
  logic [FRAC_W-1:0] t_a_q;
  logic [SQ_W-1:0]   cube_full;
  logic [POL_W-1:0]  pol;
  logic [FRAC_W-1:0] t3_d, t3_q;
  logic [P_W-1:0]    p_d, p_q;
  logic [F_W-1:0]    f_full;
  logic [FRAC_W-1:0] fade_d, fade_q;

  // Stage one: square of t.
  assign sq_d = SQ_W'(t_i) * SQ_W'(t_i);

  // Stage two: cube of t and the quadratic factor, both truncated to Q16.
  always_comb begin
    cube_full = SQ_W'(sq_q[SQ_W-1:FRAC_W]) * SQ_W'(t_a_q);
    t3_d      = cube_full[SQ_W-1:FRAC_W];
    pol       = POL_W'(sq_q) * POL_W'(FADE_K5)
              + (POL_W'(FADE_K3) << SQ_W)
              - ((POL_W'(t_a_q) * POL_W'(FADE_K4)) << FRAC_W);
    p_d       = pol[POL_W-1:FRAC_W];
  end

  // Stage three: final product with saturation.
  always_comb begin
    f_full = F_W'(t3_q) * F_W'(p_q);
    if (f_full[F_W-1:2*FRAC_W] != '0) begin
      fade_d = '1;
    end else begin
      fade_d = f_full[2*FRAC_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sq_q  <= sq_d;
      t_a_q <= t_i;
    end
    if (en_i[1]) begin
      t3_q <= t3_d;
      p_q  <= p_d;
    end
    if (en_i[2]) begin
      fade_q <= fade_d;
    end
  end

  assign fade_o = fade_q;

endmodule

/* rtl/lattice_smootherstep_interpolator_unit.sv */
// ============================================================================
// Lattice smootherstep interpolator
// Grid of lattice heights with quintic-faded bilinear interpolation between
// the corners of a cell of configurable spacing.
// ============================================================================
// Usage:
//   The slave stream carries requests. tuser says whether a request writes one
//   lattice height at (row, col) or queries the interpolated height there.
//   Writes give no result; each query gives one master-stream item.
//   The configuration channel sets the corner spacing, is always ready, and is
//   to be written while no request is in flight; only the user enforces this.
// Timing:
//   One request is accepted every cycle while the receiver does not stall.
//   The pipeline has eleven stages: cell division, two fraction-divider
//   stages, three fade stages and five blend stages, with the grid read by two
//   dual-read memory copies in the second stage.
// Reset and stall:
//   Reset empties the pipeline and sets the spacing to 5. The grid holds no
//   defined values until written and is not cleared. When the receiver stalls,
//   the stages hold their requests, bubbles close up, and s_axis_tready falls
//   only once every stage holds a request.
// ============================================================================
module lattice_smootherstep_interpolator_unit
  import lsi_pkg::*;
#(
  parameter int unsigned GRID_DIM    = 64,
  parameter int unsigned HEIGHT_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // row[5:0], col[11:6], height_in[23:12]
  input  logic                   s_axis_tuser,   // op[0]
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // height_out[11:0], zeros[15:12]
  // Spacing register write.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [SPACING_W-1:0]   cfg_data_i
);

  localparam int unsigned NSTG    = 11;
  localparam int unsigned MAX_IDX = GRID_DIM - 1;
  localparam int unsigned DEPTH   = GRID_DIM * GRID_DIM;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CRD_W   = POS_W + 1;
  localparam int unsigned PW      = HEIGHT_BITS + WGT_W;      // row blend
  localparam int unsigned HI_W    = PW - FRAC_W;              // row blend, upper part
  localparam int unsigned HP_W    = HI_W + WGT_W;             // column blend, upper part
  localparam int unsigned LP_W    = FRAC_W + WGT_W + 1;       // column blend, lower part

  // Clamp a coordinate to the last grid index.
  function automatic logic [CRD_W-1:0] clamp_pos(input logic [CRD_W-1:0] v);
    logic [CRD_W-1:0] res;
    if (32'(v) > MAX_IDX) begin
      res = CRD_W'(MAX_IDX);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Offset of a position inside its cell, by restoring division.
  function automatic logic [POS_W-1:0] cell_offset(input logic [POS_W-1:0] x,
                                                   input logic [POS_W-1:0] s);
    logic [POS_W:0] r;
    r = '0;
    for (int i = POS_W - 1; i >= 0; i--) begin
      r = {r[POS_W-1:0], x[i]};
      if (r >= {1'b0, s}) begin
        r = r - {1'b0, s};
      end
    end
    return r[POS_W-1:0];
  endfunction

  // Linear grid address of a clamped position.
  function automatic logic [ADDR_W-1:0] grid_addr(input logic [CRD_W-1:0] r,
                                                  input logic [CRD_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(GRID_DIM) + ADDR_W'(c));
  endfunction

  // --------------------------------------------------------------------------
  // Spacing register
  // --------------------------------------------------------------------------
  logic [SPACING_W-1:0] spacing_q;
  logic [POS_W-1:0]     spacing_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= SPACING_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      spacing_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  // A spacing of zero acts as one.
  assign spacing_eff = (spacing_q == '0) ? POS_W'(1) : spacing_q;

  // --------------------------------------------------------------------------
  // Valid bits and stage enables
  // --------------------------------------------------------------------------
  logic [NSTG:1] v_d, v_q;
  logic [NSTG:1] en;
  op_e           op1_q;

  // A stage loads when it is empty or its request moves on.
  always_comb begin
    en[NSTG] = !v_q[NSTG] || m_axis_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // Writes leave the pipeline once they have reached the grid.
  always_comb begin
    v_d = v_q;
    if (en[1]) begin
      v_d[1] = s_axis_tvalid;
    end
    if (en[2]) begin
      v_d[2] = v_q[1] && (op1_q == OP_QUERY);
    end
    for (int k = 3; k <= NSTG; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = en[1];

  // --------------------------------------------------------------------------
  // Stage 1: clamp the position and find its offsets in the cell
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]       row_in, col_in;
  logic [HIN_W-1:0]       hin;
  logic [CRD_W-1:0]       row_cl, col_cl;
  logic                   wr_ok_d;
  logic                   wr_ok1_q;
  logic [POS_W-1:0]       r1_q, c1_q, remr1_q, remc1_q;
  logic [HEIGHT_BITS-1:0] hw1_q;

  assign row_in  = s_axis_tdata[POS_W-1:0];
  assign col_in  = s_axis_tdata[2*POS_W-1:POS_W];
  assign hin     = s_axis_tdata[2*POS_W+HIN_W-1:2*POS_W];
  assign row_cl  = clamp_pos({1'b0, row_in});
  assign col_cl  = clamp_pos({1'b0, col_in});
  assign wr_ok_d = (32'(row_in) < GRID_DIM) && (32'(col_in) < GRID_DIM);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      op1_q    <= op_e'(s_axis_tuser);
      wr_ok1_q <= wr_ok_d;
      r1_q     <= row_cl[POS_W-1:0];
      c1_q     <= col_cl[POS_W-1:0];
      remr1_q  <= cell_offset(row_cl[POS_W-1:0], spacing_eff);
      remc1_q  <= cell_offset(col_cl[POS_W-1:0], spacing_eff);
      hw1_q    <= HEIGHT_BITS'(hin);
    end
  end

  // --------------------------------------------------------------------------
  // Grid: two copies, each written alike and read at two corners
  // --------------------------------------------------------------------------
  logic [CRD_W-1:0]       top1, left1, bot1, right1;
  logic [ADDR_W-1:0]      wr_addr;
  logic [ADDR_W-1:0]      addr_tl, addr_tr, addr_bl, addr_br;
  logic                   wr_en;
  logic [HEIGHT_BITS-1:0] mem_top_q [DEPTH];
  logic [HEIGHT_BITS-1:0] mem_bot_q [DEPTH];
  logic [1:0][HEIGHT_BITS-1:0] rd_top_q, rd_bot_q;
  logic [3:0][HEIGHT_BITS-1:0] hgt_q [3:6];

  // Cell corners; the far ones are clamped to the grid edge.
  always_comb begin
    top1    = {1'b0, r1_q - remr1_q};
    left1   = {1'b0, c1_q - remc1_q};
    bot1    = clamp_pos(top1 + {1'b0, spacing_eff});
    right1  = clamp_pos(left1 + {1'b0, spacing_eff});
    wr_addr = grid_addr({1'b0, r1_q}, {1'b0, c1_q});
    addr_tl = grid_addr(top1, left1);
    addr_tr = grid_addr(top1, right1);
    addr_bl = grid_addr(bot1, left1);
    addr_br = grid_addr(bot1, right1);
  end

  assign wr_en = v_q[1] && (op1_q == OP_WRITE) && wr_ok1_q && en[2];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_top_q[wr_addr] <= hw1_q;
    end
    if (en[2]) begin
      rd_top_q[0] <= mem_top_q[addr_tl];
      rd_top_q[1] <= mem_top_q[addr_tr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_bot_q[wr_addr] <= hw1_q;
    end
    if (en[2]) begin
      rd_bot_q[0] <= mem_bot_q[addr_bl];
      rd_bot_q[1] <= mem_bot_q[addr_br];
    end
  end

  // Corner heights ride along while the fades are formed.
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      hgt_q[3] <= {rd_bot_q, rd_top_q};
    end
    for (int k = 4; k <= 6; k++) begin
      if (en[k]) begin
        hgt_q[k] <= hgt_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2 to 6: fractions and fades for both axes
  // --------------------------------------------------------------------------
  logic [FRAC_W-1:0] tx, ty, fx, fy;

  lsi_frac u_frac_x (
    .clk_i  (clk_i),
    .en_i   (en[3:2]),
    .rem_i  (remc1_q),
    .div_i  (spacing_eff),
    .frac_o (tx)
  );

  lsi_frac u_frac_y (
    .clk_i  (clk_i),
    .en_i   (en[3:2]),
    .rem_i  (remr1_q),
    .div_i  (spacing_eff),
    .frac_o (ty)
  );

  lsi_fade u_fade_x (
    .clk_i  (clk_i),
    .en_i   (en[6:4]),
    .t_i    (tx),
    .fade_o (fx)
  );

  lsi_fade u_fade_y (
    .clk_i  (clk_i),
    .en_i   (en[6:4]),
    .t_i    (ty),
    .fade_o (fy)
  );

  // --------------------------------------------------------------------------
  // Stages 7 and 8: blend along each row
  // --------------------------------------------------------------------------
  logic [WGT_W-1:0]  wx_n, fx_w;
  logic [PW-1:0]     ptl_q, ptr_q, pbl_q, pbr_q;
  logic [FRAC_W-1:0] fy7_q, fy8_q;
  logic [PW-1:0]     topq8_q, botq8_q;

  assign fx_w = {1'b0, fx};
  assign wx_n = ONE_Q16 - fx_w;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      ptl_q <= PW'(hgt_q[6][0]) * PW'(wx_n);
      ptr_q <= PW'(hgt_q[6][1]) * PW'(fx_w);
      pbl_q <= PW'(hgt_q[6][2]) * PW'(wx_n);
      pbr_q <= PW'(hgt_q[6][3]) * PW'(fx_w);
      fy7_q <= fy;
    end
    if (en[8]) begin
      topq8_q <= ptl_q + ptr_q;
      botq8_q <= pbl_q + pbr_q;
      fy8_q   <= fy7_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 9 to 11: blend between the rows, split in upper and lower parts
  // --------------------------------------------------------------------------
  logic [WGT_W-1:0]  wy_n, fy_w;
  logic [HP_W-1:0]   pht_q, phb_q, hi10_q;
  logic [LP_W-1:0]   plt_q, plb_q, lo10_q;
  logic [HP_W-1:0]   sum11;
  logic [HOUT_W-1:0] out_d, out_q;

  assign fy_w = {1'b0, fy8_q};
  assign wy_n = ONE_Q16 - fy_w;

  always_comb begin
    sum11 = hi10_q + HP_W'(lo10_q[LP_W-1:FRAC_W]);
    out_d = HOUT_W'(sum11 >> FRAC_W);
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      pht_q <= HP_W'(topq8_q[PW-1:FRAC_W]) * HP_W'(wy_n);
      phb_q <= HP_W'(botq8_q[PW-1:FRAC_W]) * HP_W'(fy_w);
      plt_q <= LP_W'(topq8_q[FRAC_W-1:0]) * LP_W'(wy_n);
      plb_q <= LP_W'(botq8_q[FRAC_W-1:0]) * LP_W'(fy_w);
    end
    if (en[10]) begin
      hi10_q <= pht_q + phb_q;
      lo10_q <= plt_q + plb_q;
    end
    if (en[11]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = v_q[NSTG];
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);

`ifndef SYNTHESIS
  // With the output stage empty every stage can load, so a request is taken.
  a_ready_when_drained: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready
  ) else $error("request refused although the output stage is empty");

  // A write that reaches the grid never travels on as a result.
  a_write_dropped: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    v_q[1] && (op1_q == OP_WRITE) && en[2] |=> !v_q[2]
  ) else $error("write request carried past the grid stage");

  // A query in the stage before the output register that moves on lands there.
  a_result_delivered: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    v_q[NSTG-1] && en[NSTG] |=> m_axis_tvalid
  ) else $error("query lost between the blend and the output register");

  // Grid writes stay inside the grid.
  a_write_in_grid: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (32'(wr_addr) < DEPTH)
  ) else $error("grid write outside the grid");
`endif

endmodule
